### design/ebmf_pkg.sv
// Shared constants, codes and types of the edge-normalized box mean filter.
`default_nettype none
package ebmf_pkg;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_RADIUS   = 10;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int STORE_ROWS   = 2 * MAX_RADIUS + 2;
  localparam int PIXEL_BITS   = 16;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int SLOT_BITS    = $clog2(STORE_ROWS);
  localparam int STORE_DEPTH  = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_BITS    = SLOT_BITS + COL_BITS;
  localparam int WIN_SIDE     = 2 * MAX_RADIUS + 1;
  localparam int CNT_BITS     = $clog2(WIN_SIDE * WIN_SIDE + 1);
  localparam int SUM_BITS     = PIXEL_BITS + CNT_BITS;
  localparam int DIV_STEPS    = PIXEL_BITS;

  // register indexes of the configuration port
  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  // operation codes carried in tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // one word moving down the divider chain
  typedef struct packed {
    logic                  valid;
    logic [CNT_BITS-1:0]   rem;
    logic [PIXEL_BITS-1:0] low;
    logic [PIXEL_BITS-1:0] quot;
    logic [CNT_BITS-1:0]   divisor;
  } div_stage_t;
endpackage
`default_nettype wire

### design/ebmf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ebmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write or read, one access a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### design/ebmf_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands on.
`default_nettype none
module ebmf_div_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ebmf_pkg::div_stage_t din,
  output ebmf_pkg::div_stage_t    dout
);
  logic [ebmf_pkg::CNT_BITS:0] trial;
  logic                        ge;

  // shift in the next dividend bit and try the subtract
  assign trial = {din.rem, din.low[ebmf_pkg::PIXEL_BITS-1]};
  assign ge    = trial >= {1'b0, din.divisor};

  // valid is reset, the data fields just follow
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem     <= ge ? ebmf_pkg::CNT_BITS'(trial - {1'b0, din.divisor})
                       : trial[ebmf_pkg::CNT_BITS-1:0];
    dout.low     <= {din.low[ebmf_pkg::PIXEL_BITS-2:0], 1'b0};
    dout.quot    <= {din.quot[ebmf_pkg::PIXEL_BITS-2:0], ge};
    dout.divisor <= din.divisor;
  end
endmodule
`default_nettype wire

### design/ebmf_div_chain.sv
// Row of division cells; a word enters at the first cell and is registered in each one on its way out.
`default_nettype none
module ebmf_div_chain (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ebmf_pkg::div_stage_t din,
  output ebmf_pkg::div_stage_t      dout
);
  ebmf_pkg::div_stage_t stage [0:ebmf_pkg::DIV_STEPS];

  assign stage[0] = din;

  for (genvar i = 0; i < ebmf_pkg::DIV_STEPS; i++) begin : g_cell
    ebmf_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign dout = stage[ebmf_pkg::DIV_STEPS];
endmodule
`default_nettype wire

### design/edge_normalized_box_mean_filter.sv
// A word whose result is ready has the N in-frame pixels of its window (up to 441) read,
// one per cycle from the line store port, then summed and divided in the divider cell chain,
// and m_tvalid then rises. A word with no result returns to idle after its check.
// One word at a time: the next word is taken once m_tready has taken the result, or once
// a word without one has been checked.
// Reset: positions cleared, radius 1, width 1024, height 1024; line store not cleared.
`default_nettype none
module edge_normalized_box_mean_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // pixel[15:0]
  input  wire logic [0:0]  s_tuser,   // operation[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // mean[15:0]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  localparam int CB = ebmf_pkg::COL_BITS;
  localparam int RB = ebmf_pkg::ROW_BITS;
  localparam int SB = ebmf_pkg::SLOT_BITS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_READ  = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [3:0]  radius;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [RB-1:0] in_row;
  logic [CB-1:0] in_col;
  logic [SB-1:0] in_slot;
  logic [RB:0]   out_row;
  logic [CB-1:0] out_col;
  logic [SB-1:0] out_slot;
  logic          frame_full;
  logic [SB-1:0] rd_slot;
  logic [CB-1:0] rd_col, c0_q, c1_q;
  logic [SB-1:0] rows_left;
  logic          acc_en;
  logic [ebmf_pkg::SUM_BITS-1:0] acc;
  logic [ebmf_pkg::CNT_BITS-1:0] cnt;
  logic [15:0] mean_q;
  logic        fe_q;

  // effective settings
  logic [3:0]    r_eff;
  logic [CB-1:0] w_m1;
  logic [RB-1:0] h_m1;
  assign r_eff = (radius > 4'(ebmf_pkg::MAX_RADIUS)) ? 4'(ebmf_pkg::MAX_RADIUS) : radius;
  assign w_m1  = (frame_width == '0) ? '0 :
                 (frame_width > 11'(ebmf_pkg::MAX_WIDTH)) ? CB'(ebmf_pkg::MAX_WIDTH - 1) :
                 CB'(frame_width - 11'd1);
  assign h_m1  = (frame_height == '0) ? '0 :
                 (frame_height > 13'(ebmf_pkg::HEIGHT_LIMIT)) ?
                 RB'(ebmf_pkg::HEIGHT_LIMIT - 1) : RB'(frame_height - 13'd1);

  // handshakes; a register write only lands while idle and wins over an input word
  logic s_acc, cfg_hit, pix_acc;
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign pix_acc   = s_acc && (s_tuser[0] == ebmf_pkg::OP_PIXEL);
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == ebmf_pkg::REG_RADIUS ||
                      cfg_index == ebmf_pkg::REG_FRAME_WIDTH ||
                      cfg_index == ebmf_pkg::REG_FRAME_HEIGHT);

  // write position, restarted when a full frame is followed by a pixel
  logic [RB-1:0] wr_row;
  logic [CB-1:0] wr_col;
  logic [SB-1:0] wr_slot;
  assign wr_row  = frame_full ? '0 : in_row;
  assign wr_col  = frame_full ? '0 : in_col;
  assign wr_slot = frame_full ? '0 : in_slot;

  // readiness of the next result
  logic [RB:0]   need_row_raw, need_row;
  logic [CB:0]   need_col_raw, need_col;
  logic          out_ready;
  assign need_row_raw = out_row + (RB+1)'(r_eff);
  assign need_row     = (need_row_raw > {1'b0, h_m1}) ? {1'b0, h_m1} : need_row_raw;
  assign need_col_raw = {1'b0, out_col} + (CB+1)'(r_eff);
  assign need_col     = (need_col_raw > {1'b0, w_m1}) ? {1'b0, w_m1} : need_col_raw;
  assign out_ready = (out_row <= {1'b0, h_m1}) &&
                     (frame_full || ({1'b0, in_row} > need_row) ||
                      ({1'b0, in_row} == need_row && {1'b0, in_col} > need_col));

  // window bounds
  logic [3:0]    d_up;
  logic [RB:0]   r0;
  logic [SB:0]   slot_wrap;
  logic [SB-1:0] start_slot;
  logic [CB-1:0] c0, c1;
  assign d_up       = (out_row < (RB+1)'(r_eff)) ? out_row[3:0] : r_eff;
  assign r0         = out_row - (RB+1)'(d_up);
  assign slot_wrap  = {1'b0, out_slot} + (SB+1)'(ebmf_pkg::STORE_ROWS) - (SB+1)'(d_up);
  assign start_slot = (out_slot >= SB'(d_up)) ? SB'(out_slot - SB'(d_up)) : slot_wrap[SB-1:0];
  assign c0         = (out_col > CB'(r_eff)) ? CB'(out_col - CB'(r_eff)) : '0;
  assign c1         = need_col[CB-1:0];

  // line store
  logic [ebmf_pkg::ADDR_BITS-1:0]  ram_addr;
  logic [ebmf_pkg::PIXEL_BITS-1:0] rd_data;
  assign ram_addr = pix_acc ? {wr_slot, wr_col} : {rd_slot, rd_col};

  ebmf_ram #(
    .WIDTH (ebmf_pkg::PIXEL_BITS),
    .DEPTH (ebmf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (pix_acc),
    .addr  (ram_addr),
    .wdata (s_tdata),
    .rdata (rd_data)
  );

  // divider feed: last read folded in on the way
  logic [ebmf_pkg::SUM_BITS-1:0] acc_total;
  ebmf_pkg::div_stage_t div_in, div_out;
  assign acc_total      = acc + ebmf_pkg::SUM_BITS'(rd_data);
  assign div_in.valid   = (state == ST_SUM);
  assign div_in.rem     = acc_total[ebmf_pkg::SUM_BITS-1:ebmf_pkg::PIXEL_BITS];
  assign div_in.low     = acc_total[ebmf_pkg::PIXEL_BITS-1:0];
  assign div_in.quot    = '0;
  assign div_in.divisor = cnt + 1'b1;

  ebmf_div_chain u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (div_in),
    .dout (div_out)
  );

  // next slots
  logic [SB-1:0] in_slot_inc, out_slot_inc, rd_slot_inc;
  assign in_slot_inc  = (wr_slot == SB'(ebmf_pkg::STORE_ROWS - 1)) ? '0 : wr_slot + 1'b1;
  assign out_slot_inc = (out_slot == SB'(ebmf_pkg::STORE_ROWS - 1)) ? '0 : out_slot + 1'b1;
  assign rd_slot_inc  = (rd_slot == SB'(ebmf_pkg::STORE_ROWS - 1)) ? '0 : rd_slot + 1'b1;

  // control and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      radius       <= 4'd1;
      frame_width  <= 11'd1024;
      frame_height <= 13'd1024;
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
      frame_full <= 1'b0;
      m_tvalid   <= 1'b0;
      acc_en     <= 1'b0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        ebmf_pkg::REG_RADIUS:      radius       <= cfg_data[3:0];
        ebmf_pkg::REG_FRAME_WIDTH: frame_width  <= cfg_data[10:0];
        default:                   frame_height <= cfg_data;
      endcase
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
      frame_full <= 1'b0;
    end else begin
      acc_en <= (state == ST_READ);
      unique case (state)
        ST_IDLE: begin
          if (pix_acc) begin
            if (frame_full) begin
              out_row <= '0; out_col <= '0; out_slot <= '0;
            end
            frame_full <= (wr_col == w_m1) && (wr_row == h_m1);
            if (wr_col == w_m1) begin
              in_col <= '0;
              if (wr_row == h_m1) begin
                in_row <= '0; in_slot <= '0;
              end else begin
                in_row <= wr_row + 1'b1; in_slot <= in_slot_inc;
              end
            end else begin
              in_col <= wr_col + 1'b1;
              in_row <= wr_row; in_slot <= wr_slot;
            end
          end
          if (s_acc) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (out_ready) begin
            rd_slot   <= start_slot;
            rd_col    <= c0;
            c0_q      <= c0;
            c1_q      <= c1;
            rows_left <= SB'(need_row - r0);
            acc       <= '0;
            cnt       <= '0;
            fe_q      <= (out_row == {1'b0, h_m1}) && (out_col == w_m1);
            if (out_col == w_m1) begin
              out_col <= '0; out_row <= out_row + 1'b1; out_slot <= out_slot_inc;
            end else begin
              out_col <= out_col + 1'b1;
            end
            state <= ST_READ;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (rd_col == c1_q) begin
            rd_col <= c0_q;
            if (rows_left == '0) begin
              state <= ST_SUM;
            end else begin
              rows_left <= rows_left - 1'b1;
              rd_slot   <= rd_slot_inc;
            end
          end else begin
            rd_col <= rd_col + 1'b1;
          end
        end
        ST_SUM: state <= ST_DIV;
        ST_DIV: begin
          if (div_out.valid) begin
            mean_q   <= div_out.quot;
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // window accumulation, one pixel per cycle
      if (acc_en && state == ST_READ) begin
        acc <= acc_total;
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign m_tdata = mean_q;
  assign m_tlast = fe_q;

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input taken while a result waits");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_out.valid |-> state == ST_DIV)
    else $error("divider result outside divide wait");
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken before first finished");
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the edge-normalized box mean filter.
module testbench;
  localparam int DRAIN_WAIT = 480;      // longest result word plus margin
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [15:0] mean;
    logic        last;
  } mean_word_t;

  // Predicts window means and holds the expected words in order
  class box_mean_scoreboard;
    logic [15:0] line_rows [ebmf_pkg::STORE_DEPTH];
    int unsigned in_r, in_c, out_r, out_c;
    bit frame_done;
    int unsigned rad_reg, wid_reg, hgt_reg;
    mean_word_t expected_means [$];
    int errors;

    function new();
      rad_reg = 1;
      wid_reg = 1024;
      hgt_reg = 1024;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      frame_done = 0;
    endfunction

    function int unsigned eff_w();
      if (wid_reg == 0) return 1;
      return (wid_reg > ebmf_pkg::MAX_WIDTH) ? ebmf_pkg::MAX_WIDTH : wid_reg;
    endfunction

    function int unsigned eff_h();
      if (hgt_reg == 0) return 1;
      return (hgt_reg > ebmf_pkg::HEIGHT_LIMIT) ? ebmf_pkg::HEIGHT_LIMIT : hgt_reg;
    endfunction

    function int unsigned eff_r();
      return (rad_reg > ebmf_pkg::MAX_RADIUS) ? ebmf_pkg::MAX_RADIUS : rad_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] data);
      case (idx)
        ebmf_pkg::REG_RADIUS:       rad_reg = data[3:0];
        ebmf_pkg::REG_FRAME_WIDTH:  wid_reg = data[10:0];
        ebmf_pkg::REG_FRAME_HEIGHT: hgt_reg = data;
        default: return;
      endcase
      restart();
    endfunction

    // true while the next word would give a result; ready once the far corner arrived
    function bit frame_pending();
      int unsigned w, h, r, need_r, need_c;
      w = eff_w(); h = eff_h(); r = eff_r();
      if (out_r >= h) return 0;
      if (frame_done) return 1;
      need_r = (out_r + r > h - 1) ? h - 1 : out_r + r;
      need_c = (out_c + r > w - 1) ? w - 1 : out_c + r;
      return in_r > need_r || (in_r == need_r && in_c > need_c);
    endfunction

    // note an accepted input word and predict its result, if any
    function void add_word(logic op, logic [15:0] pix);
      int unsigned w, h, r, r0, r1, c0, c1;
      longint unsigned sum, cnt;
      mean_word_t res;
      w = eff_w(); h = eff_h(); r = eff_r();
      if (op == ebmf_pkg::OP_PIXEL) begin
        if (frame_done) restart();
        line_rows[(in_r % ebmf_pkg::STORE_ROWS) * ebmf_pkg::MAX_WIDTH + in_c] = pix;
        in_c++;
        if (in_c >= w) begin
          in_c = 0;
          in_r++;
          if (in_r >= h) begin
            in_r = 0;
            frame_done = 1;
          end
        end
      end
      if (!frame_pending()) return;
      r0 = (out_r > r) ? out_r - r : 0;
      r1 = (out_r + r > h - 1) ? h - 1 : out_r + r;
      c0 = (out_c > r) ? out_c - r : 0;
      c1 = (out_c + r > w - 1) ? w - 1 : out_c + r;
      sum = 0; cnt = 0;
      for (int unsigned y = r0; y <= r1; y++)
        for (int unsigned x = c0; x <= c1; x++) begin
          sum += line_rows[(y % ebmf_pkg::STORE_ROWS) * ebmf_pkg::MAX_WIDTH + x];
          cnt++;
        end
      res.mean = 16'(sum / cnt);
      res.last = (out_r == h - 1 && out_c == w - 1);
      expected_means.push_back(res);
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    endfunction

    function void check_result(logic [15:0] mean, logic last);
      mean_word_t exp_w;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result mean=%0d last=%0b", $time, mean, last);
        errors++;
        return;
      end
      exp_w = expected_means.pop_front();
      if (mean !== exp_w.mean) begin
        $display("%0t: mean mismatch expected %0d actual %0d", $time, exp_w.mean, mean);
        errors++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: frame end mismatch expected %0b actual %0b", $time, exp_w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  box_mean_scoreboard sb = new();
  int cycles = 0;
  int words_sent = 0;
  bit no_idle = 0;
  int stall_left = 0;

  edge_normalized_box_mean_filter uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check each taken result, then random back-pressure unless no_idle
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    if (no_idle) m_tready <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 99) < 75) m_tready <= 1;
    else begin
      m_tready <= 0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
    end
  end

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic op, logic [15:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    sb.add_word(op, pix);
    words_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (sb.expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_frame(logic [12:0] rad, logic [12:0] wid, logic [12:0] hgt);
    wait_idle();
    write_reg(ebmf_pkg::REG_RADIUS, rad);
    write_reg(ebmf_pkg::REG_FRAME_WIDTH, wid);
    write_reg(ebmf_pkg::REG_FRAME_HEIGHT, hgt);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int unsigned n, bit noise);
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        send_word(ebmf_pkg::OP_DRAIN, 16'($urandom));
      send_word(ebmf_pkg::OP_PIXEL, rand_pixel());
    end
  endtask

  task automatic drain_frame();
    while (sb.frame_pending()) send_word(ebmf_pkg::OP_DRAIN, 16'($urandom));
  endtask

  initial begin
    int unsigned w, h, n;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, drain with nothing pending, abandoned frame
    set_frame(13'd1, 13'd3, 13'd2);
    send_word(ebmf_pkg::OP_DRAIN, 16'hFFFF);
    send_word(ebmf_pkg::OP_PIXEL, 16'h0000);
    send_word(ebmf_pkg::OP_PIXEL, 16'hFFFF);
    send_word(ebmf_pkg::OP_PIXEL, 16'hFFFF);
    send_word(ebmf_pkg::OP_PIXEL, 16'h0001);
    send_word(ebmf_pkg::OP_PIXEL, 16'hFFFE);
    send_word(ebmf_pkg::OP_PIXEL, 16'h8000);
    // next frame starts before the drain: pending results are dropped
    send_frame(6, 0);
    drain_frame();
    send_word(ebmf_pkg::OP_DRAIN, 16'h0000);
    set_frame(13'h1FF0, 13'h1802, 13'd3);
    send_frame(6, 0);
    drain_frame();

    // random frames, mostly small
    while (words_sent < 250) begin
      no_idle = ($urandom_range(0, 5) == 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      set_frame({9'($urandom), 4'($urandom_range(0, 15))},
                {2'($urandom), 11'(w)}, 13'(h));
      if (w == 0) w = 1;
      repeat ($urandom_range(1, 3)) begin
        n = w * h;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        send_frame(n, 1);
        case ($urandom_range(0, 9))
          0, 1: ;
          2: repeat ($urandom_range(0, 3)) send_word(ebmf_pkg::OP_DRAIN, 16'($urandom));
          default: begin
            drain_frame();
            repeat ($urandom_range(0, 2)) send_word(ebmf_pkg::OP_DRAIN, 16'($urandom));
          end
        endcase
      end
    end
    no_idle = 0;

    // register extremes: widest row, oversized height and radius, zero encodings
    set_frame(13'd0, 13'd2047, 13'd0);
    send_frame(1024, 0);
    drain_frame();
    set_frame(13'd15, 13'd1, 13'd8191);
    send_frame(60, 0);
    drain_frame();
    set_frame(13'd10, 13'd0, 13'd1);
    send_frame(1, 0);
    drain_frame();

    wait_idle();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
